/* design/isort_pkg.sv */
`default_nettype none

package isort_pkg;

   // One input beat: the element and the end-of-set mark.
   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_result;
      logic               overflow;
   } rsp_type;

   // Memory port controls driven by the sequencer.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

endpackage

`default_nettype wire

/* design/isort_store.sv */
`default_nettype none

module isort_store
   import isort_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire                       clock,
   input  mem_ctl_type               mem_ctl,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire signed [31:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [31:0]        rd_data
);

   logic signed [31:0] mem_ff [DEPTH];

   // Single write port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/isort_seq.sv */
`default_nettype none

module isort_seq
   import isort_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  req_type                      req_data,
   output logic                         busy,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data,
   output mem_ctl_type                  mem_ctl,
   output logic [$clog2(CAPACITY)-1:0]  wr_addr,
   output logic signed [31:0]           wr_data,
   output logic [$clog2(CAPACITY)-1:0]  rd_addr,
   input  wire signed [31:0]            rd_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic             store_full;
   logic             new_less;
   logic             emit_last;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // Working registers of the current element.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      pos_ff <= pos_in;
      k_ff   <= k_in;
   end

   // The shared comparator: new element against the stored entry just read.
   assign new_less   = req_ff.value < rd_data;
   assign store_full = count_ff == CW'(CAPACITY);
   assign emit_last  = CW'(k_ff) == (count_ff - CW'(1));

   // Next state, memory control and result beat.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      pos_in        = pos_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = req_ff.value;
      rd_addr       = pos_ff - AW'(1);
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      rsp_data.sorted_value = rd_data;
      rsp_data.last_result  = emit_last;
      rsp_data.overflow     = dropped_ff;

      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            k_in = '0;
            if (start) begin
               req_in = req_data;
               pos_in = count_ff[AW-1:0];
               if (store_full) begin
                  // The element is dropped; the store keeps its contents.
                  dropped_in = 1'b1;
                  state_in   = req_data.last_item ? ST_EMIT_RD : ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (pos_ff == '0) begin
               // Reached the bottom of the store: place the element here.
               mem_ctl.wr_en = 1'b1;
               count_in      = count_ff + CW'(1);
               state_in      = req_ff.last_item ? ST_EMIT_RD : ST_IDLE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = ST_CMP;
            end
         end

         ST_CMP: begin
            mem_ctl.wr_en = 1'b1;
            if (new_less) begin
               // Move the larger entry up one place and keep scanning.
               wr_data  = rd_data;
               pos_in   = pos_ff - AW'(1);
               state_in = ST_SCAN;
            end else begin
               // Equal or smaller entry found: the element goes above it.
               count_in = count_ff + CW'(1);
               state_in = req_ff.last_item ? ST_EMIT_RD : ST_IDLE;
            end
         end

         ST_EMIT_RD: begin
            rd_addr       = k_ff;
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (emit_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/insertion_sorter.sv */
`default_nettype none

// Streaming stable insertion sorter for signed 32-bit values.
// Input: drive req_data and raise start; the beat is taken at an edge where
// start is high and busy is low. Elements not marked last_item produce no
// result. An element arriving while the store holds CAPACITY entries is
// dropped and every result of that run carries overflow.
// Output: when the element marked last_item has been inserted or dropped,
// the block emits every stored value in ascending order, never back to back,
// each shown for one cycle with rsp_valid; the final beat has last_result.
// The receiver cannot stall; results must be taken as they appear.
// Insertion: busy stays high while the sequencer scans the store from the
// top, one entry per read, through the single memory read port and the one
// comparator that it reuses per scanned entry; each entry larger than the
// new value moves up one place. A full store drops a beat not marked
// last_item without raising busy.
// Reset: clears the fill count and the overflow mark; the block is idle
// in the first cycle after reset. Stored data is not cleared.

module insertion_sorter
   import isort_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  req_type  req_data,
   output logic     busy,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int AW = $clog2(CAPACITY);

   mem_ctl_type         mem_ctl;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic signed [31:0]  wr_data;
   logic signed [31:0]  rd_data;

   // Sequencer with the shared comparator.
   isort_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Sorted store.
   isort_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Results only appear while the block is busy.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   // Result beats are never back to back.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

   // An accepted element not marked last causes no result next cycle.
   a_no_rsp_mid: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.last_item) |=> !rsp_valid)
      else $error("result after an element not marked last");

   // Reset leaves the block idle.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

`default_nettype wire

/* test/insertion_sorter_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the sorter, keeps its own sorted copy of the
// current set and compares every result beat with the oldest expected one.
module insertion_sorter_checker
   import isort_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  wire      busy,
   input  req_type  req_data,
   input  wire      rsp_valid,
   input  rsp_type  rsp_data,
   output int       fail_count = 0,
   output int       pending_count = 0
);

   // Shadow of the sorted store for the set being loaded.
   logic signed [31:0] shadow_store [CAPACITY];
   int                 shadow_fill;
   logic               shadow_dropped;

   // Sorted results still owed by the block, oldest first.
   rsp_type expected_sorted [$];

   // Insert one element the way the block does; on the last element of a
   // set, queue the whole sorted set and empty the shadow store.
   task automatic insert_element(input req_type beat);
      logic signed [31:0] v;
      int                 pos;
      rsp_type            res;
      v = beat.value;
      if (shadow_fill >= CAPACITY) begin
         // Store full: the element is dropped, the last mark still ends the set.
         shadow_dropped = 1'b1;
      end else begin
         // Larger entries move up; equal ones stay below the new element.
         pos = shadow_fill;
         while (pos > 0 && v < shadow_store[pos - 1]) begin
            shadow_store[pos] = shadow_store[pos - 1];
            pos--;
         end
         shadow_store[pos] = v;
         shadow_fill++;
      end
      if (beat.last_item) begin
         for (int k = 0; k < shadow_fill; k++) begin
            res.sorted_value = shadow_store[k];
            res.last_result  = (k == shadow_fill - 1);
            res.overflow     = shadow_dropped;
            expected_sorted.push_back(res);
         end
         shadow_fill    = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   // Compare one result beat field by field with the oldest expectation.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_sorted.size() == 0) begin
         $error("result beat with none expected: sorted_value %0d", got.sorted_value);
         fail_count++;
      end else begin
         want = expected_sorted.pop_front();
         if (got.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   want.sorted_value, got.sorted_value);
            fail_count++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0b, actual %0b",
                   want.last_result, got.last_result);
            fail_count++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
            fail_count++;
         end
      end
   endtask

   // Sample both channels at the clock edge where their beats are taken.
   always @(posedge clock) begin
      if (reset) begin
         shadow_fill    = 0;
         shadow_dropped = 1'b0;
         expected_sorted.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            check_result(rsp_data);
         end
         if (start === 1'b1 && busy === 1'b0) begin
            insert_element(req_data);
         end
      end
      pending_count = expected_sorted.size();
   end

endmodule

/* test/insertion_sorter_tb.sv */
`timescale 1ns / 1ps

// Drives sets of signed elements into the sorter and gives the verdict;
// all result checking happens in the sort checker instantiated beside the block.
module insertion_sorter_tb;
   import isort_pkg::*;

   localparam int CAPACITY = 32;
   localparam int RANDOM_ITEMS = 210;
   // Longest quiet stretch of a correct run: the longest gap between beats, an
   // insertion that shifts a full store and an emit of 32 results, with
   // plenty of margin.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to watch for stray results once everything has arrived.
   localparam int TAIL_CYCLES = 20;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      idle_cycles = 0;

   insertion_sorter #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   insertion_sorter_checker #(
      .CAPACITY(CAPACITY)
   ) u_sort_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** insertion_sorter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one element after an optional gap and hold it until taken.
   // Called and returns at a rising edge; start stays high for a following beat.
   task automatic send_beat(input logic signed [31:0] v, input logic fin, input int gap);
      req_type beat;
      beat.value     = v;
      beat.last_item = fin;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending until every owed result has come out.
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly no gap, some short ones and a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Full-range values, plus a narrow band that produces many equal values
   // and the range extremes.
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom();
      if (r < 8) return int'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 3))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   initial begin
      int  sent;
      int  set_index;
      int  set_len;
      int  r;
      bit  steady;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed sets: a single element, the extremes, equal values,
      // descending input (deepest shifting) and ascending input.
      send_beat(VALUE_MIN, 1'b1, 0);
      send_beat(VALUE_MAX, 1'b0, 0);
      send_beat(VALUE_MIN, 1'b0, 0);
      send_beat(32'sd0, 1'b0, 2);
      send_beat(-32'sd1, 1'b0, 0);
      send_beat(32'sd1, 1'b1, 0);
      send_beat(32'sd7, 1'b0, 0);
      send_beat(-32'sd3, 1'b0, 1);
      send_beat(32'sd7, 1'b0, 0);
      send_beat(32'sd7, 1'b1, 0);
      for (int i = 5; i >= 1; i--) begin
         send_beat(i, i == 1, 0);
      end
      for (int i = -2; i <= 1; i++) begin
         send_beat(i, i == 1, 0);
      end
      send_beat(VALUE_MAX, 1'b0, 0);
      send_beat(VALUE_MAX, 1'b1, 0);
      wait_drained();

      // Random sets. The first one overfills the store so that the element
      // marked last is itself dropped; the second fills it exactly.
      sent = 0;
      set_index = 0;
      while (sent < RANDOM_ITEMS) begin
         if (set_index == 0) begin
            set_len = CAPACITY + 1;
         end else if (set_index == 1) begin
            set_len = CAPACITY;
         end else begin
            r = $urandom_range(0, 9);
            if (r < 7) set_len = $urandom_range(1, 8);
            else if (r < 9) set_len = $urandom_range(9, CAPACITY);
            else set_len = $urandom_range(CAPACITY + 1, CAPACITY + 5);
         end
         steady = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_len; i++) begin
            send_beat(pick_value(), i == set_len - 1, steady ? 0 : pick_gap());
         end
         sent += set_len;
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
         end
         set_index++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** insertion_sorter: PASSED **");
      end else begin
         $display("** insertion_sorter: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
design/isort_pkg.sv
design/isort_store.sv
design/isort_seq.sv
design/insertion_sorter.sv
test/insertion_sorter_checker.sv
test/insertion_sorter_tb.sv
